/* rtl/interleaved_channel_block_averager_macros.svh */
// ----------------------------------------------------------------------------
// Interleaved channel block averager - assertion macros
// Shared concurrent assertion helpers, clocked on the rising edge and
// disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_CHANNEL_BLOCK_AVERAGER_MACROS_SVH
`define INTERLEAVED_CHANNEL_BLOCK_AVERAGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ICBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ICBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/icba_pkg.sv */
// ----------------------------------------------------------------------------
// icba_pkg
// Types, constants and helpers shared by the block averager modules.
// ----------------------------------------------------------------------------
package icba_pkg;

    localparam int unsigned MAX_CHANNELS = 8;
    localparam int unsigned MAX_FRAMES   = 256;
    localparam int unsigned SAMPLE_W     = 12;
    localparam int unsigned INDEX_W      = 3;
    localparam int unsigned CHANS_W      = 4;
    localparam int unsigned FRAMES_W     = 9;
    localparam int unsigned FRAME_POS_W  = 8;
    localparam int unsigned SUM_W        = 20;
    localparam int unsigned DIV_CNT_W    = 5;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [SAMPLE_W-1:0] READING_MAX = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX     = '1;

    // Register indexes on the configuration port
    localparam logic REG_CHANNEL_COUNT    = 1'b0;
    localparam logic REG_FRAMES_PER_BLOCK = 1'b1;

    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    // One classified transaction travelling from front to back
    typedef struct packed
    {
        func_t                func;
        logic [SAMPLE_W-1:0]  sample;
        logic [INDEX_W-1:0]   index;
    } item_t;

    typedef struct packed
    {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [FRAMES_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed
    {
        logic                 done;
        logic [SUM_W-1:0]     quotient;
    } div_rsp_t;

    // Channel count in use: zero counts as one, large values saturate
    function automatic logic [CHANS_W-1:0] eff_chans(input logic [CHANS_W-1:0] cc);
        logic [CHANS_W-1:0] r;
        if (cc == '0)
            r = CHANS_W'(1);
        else if (cc > CHANS_W'(MAX_CHANNELS))
            r = CHANS_W'(MAX_CHANNELS);
        else
            r = cc;
        return r;
    endfunction

    // Frames per block in use: zero counts as one, large values saturate
    function automatic logic [FRAMES_W-1:0] eff_frames(input logic [FRAMES_W-1:0] fpb);
        logic [FRAMES_W-1:0] r;
        if (fpb == '0)
            r = FRAMES_W'(1);
        else if (fpb > FRAMES_W'(MAX_FRAMES))
            r = FRAMES_W'(MAX_FRAMES);
        else
            r = fpb;
        return r;
    endfunction

endpackage

/* rtl/icba_front.sv */
// ----------------------------------------------------------------------------
// icba_front
// Input stage: takes transactions, clamps the read index and holds the
// classified item until the queue takes it.
// ----------------------------------------------------------------------------
module icba_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [icba_pkg::SAMPLE_W-1:0] sample,
    input  logic [icba_pkg::INDEX_W-1:0]  channel_index,
    input  logic [icba_pkg::CHANS_W-1:0]  chans,
    output logic                          push_valid,
    input  logic                          push_ready,
    output icba_pkg::item_t               push_item
);
    import icba_pkg::*;

    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic [CHANS_W-1:0] last_chan;

    // Clamp read index to the last active channel
    always_comb
    begin
        last_chan        = chans - CHANS_W'(1);
        item_next.func   = func_t'(func);
        item_next.sample = sample;
        if ({1'b0, channel_index} > last_chan)
            item_next.index = last_chan[INDEX_W-1:0];
        else
            item_next.index = channel_index;
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    // Holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/icba_queue.sv */
// ----------------------------------------------------------------------------
// icba_queue
// Two-entry queue between the front and back stages.
// ----------------------------------------------------------------------------
`include "interleaved_channel_block_averager_macros.svh"

module icba_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  icba_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop,
    output icba_pkg::item_t pop_item
);
    import icba_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ICBA_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue over depth")

endmodule

/* rtl/icba_div.sv */
// ----------------------------------------------------------------------------
// icba_div
// Restoring divider, one quotient bit per cycle, for the block means.
// ----------------------------------------------------------------------------
module icba_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  icba_pkg::div_req_t req,
    output icba_pkg::div_rsp_t rsp
);
    import icba_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     dvd_reg;
    logic [FRAMES_W-1:0]  dvs_reg;
    logic [FRAMES_W-1:0]  rem_reg;
    logic [FRAMES_W:0]    rem_sh;
    logic [FRAMES_W:0]    rem_sub;
    logic                 ge;

    // One shift-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // done pulses for one cycle after the last step
            done_reg <= !req.start && busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath; quotient bits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[FRAMES_W-1:0] : rem_sh[FRAMES_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

/* rtl/icba_back.sv */
// ----------------------------------------------------------------------------
// icba_back
// Execution stage: accumulates samples, tracks slot and frame, walks the
// channels through the divider at block end and serves reads.
// ----------------------------------------------------------------------------
`include "interleaved_channel_block_averager_macros.svh"

module icba_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  icba_pkg::item_t               q_item,
    output logic                          q_pop,
    input  logic [icba_pkg::CHANS_W-1:0]  chans,
    input  logic [icba_pkg::FRAMES_W-1:0] frames,
    output icba_pkg::div_req_t            div_req,
    input  icba_pkg::div_rsp_t            div_rsp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [icba_pkg::SAMPLE_W-1:0] reading,
    output logic                          block_done
);
    import icba_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT
    } state_t;

    state_t                   state_reg;
    logic [SUM_W-1:0]         sums_reg  [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]      means_reg [MAX_CHANNELS];
    logic [INDEX_W-1:0]       slot_reg;
    logic [INDEX_W-1:0]       slot_next;
    logic [FRAME_POS_W-1:0]   frame_reg;
    logic [FRAME_POS_W-1:0]   frame_next;
    logic [INDEX_W-1:0]       chan_reg;
    logic                     out_valid_reg;
    logic [SAMPLE_W-1:0]      reading_reg;
    logic                     block_done_reg;

    logic                     out_free;
    logic                     out_set;
    logic [INDEX_W-1:0]       sum_addr;
    logic [SUM_W-1:0]         sum_rd;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;
    logic [INDEX_W-1:0]       slot_inc;
    logic                     slot_wrap;
    logic [FRAMES_W-1:0]      frame_inc;
    logic                     block_end;
    logic                     last_chan;
    logic [SAMPLE_W-1:0]      mean_sat;

    // Accumulate, advance slot and frame
    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        q_pop     = (state_reg == ST_IDLE) && q_valid && out_free;
        sum_addr  = (state_reg == ST_IDLE) ? slot_reg : chan_reg;
        sum_rd    = sums_reg[sum_addr];
        sum_wide  = {1'b0, sum_rd} + (SUM_W + 1)'(q_item.sample);
        sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        slot_inc  = slot_reg + 1'b1;
        slot_wrap = ({1'b0, slot_inc} >= chans) || (slot_inc == '0);
        frame_inc = {1'b0, frame_reg} + 1'b1;
        block_end = slot_wrap && (frame_inc >= frames);
        slot_next = slot_wrap ? '0 : slot_inc;
        if (!slot_wrap)
            frame_next = frame_reg;
        else if (block_end)
            frame_next = '0;
        else
            frame_next = frame_inc[FRAME_POS_W-1:0];
    end

    // Divider hookup and mean saturation
    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = sum_rd;
        div_req.divisor  = frames;
        last_chan        = ({1'b0, chan_reg} == (chans - CHANS_W'(1)));
        if (div_rsp.quotient > SUM_W'(READING_MAX))
            mean_sat = READING_MAX;
        else
            mean_sat = div_rsp.quotient[SAMPLE_W-1:0];
    end

    // Result register loads on a read, an ordinary push or the end of the walk
    assign out_set = (q_pop && ((q_item.func == FUNC_READ) || !block_end))
                     || ((state_reg == ST_DIV_WAIT) && div_rsp.done && last_chan);

    // Sequencer, state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            frame_reg      <= '0;
            chan_reg       <= '0;
            out_valid_reg  <= 1'b0;
            reading_reg    <= '0;
            block_done_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                sums_reg[i]  <= '0;
                means_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_set)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_item.func == FUNC_READ)
                        begin
                            reading_reg    <= means_reg[q_item.index];
                            block_done_reg <= 1'b0;
                        end
                        else
                        begin
                            sums_reg[slot_reg] <= sum_sat;
                            slot_reg           <= slot_next;
                            frame_reg          <= frame_next;
                            if (block_end)
                            begin
                                chan_reg  <= '0;
                                state_reg <= ST_DIV_START;
                            end
                            else
                            begin
                                reading_reg    <= '0;
                                block_done_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        means_reg[chan_reg] <= mean_sat;
                        if (last_chan)
                        begin
                            for (int i = 0; i < MAX_CHANNELS; i++)
                            begin
                                sums_reg[i] <= '0;
                            end
                            reading_reg    <= '0;
                            block_done_reg <= 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            chan_reg  <= chan_reg + 1'b1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign reading    = reading_reg;
    assign block_done = block_done_reg;

    `ICBA_ASSERT_SAME(a_walk_out_empty, clk, rst_n, state_reg != ST_IDLE, !out_valid_reg, "result pending during mean walk")
    `ICBA_ASSERT_SAME(a_done_no_reading, clk, rst_n, out_valid_reg && block_done_reg, reading_reg == '0, "block_done with nonzero reading")
    `ICBA_ASSERT_NEXT(a_div_kick, clk, rst_n, div_req.start, state_reg == ST_DIV_WAIT, "divider start without wait")

endmodule

/* rtl/interleaved_channel_block_averager.sv */
// ----------------------------------------------------------------------------
// interleaved_channel_block_averager
// Per-channel block mean of a round-robin interleaved ADC sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : func/sample/channel_index under in_valid/in_ready. func 0
//                 pushes a sample to the current slot, func 1 reads a
//                 channel's stored mean (index clamped to the last channel).
//   out channel : one reading/block_done result per input transaction,
//                 under out_valid/out_ready, in input order.
//   cfg channel : cfg_index/cfg_data under cfg_valid/cfg_ready (always
//                 ready); index 0 channel_count, index 1 frames_per_block.
//   Path        : front, queue and result registers; one transaction per
//                 cycle sustained while out_ready holds and no walk runs.
//   Block end   : the push that closes a block walks the active channels
//                 through a bit-serial divider one channel after another;
//                 its result is set at the end of the walk.
//   Reset       : readings, sums, slot and frame cleared; registers back to
//                 4 channels and 256 frames. No clearing pass.
//   Stalls      : a two-entry queue and an output register decouple the
//                 sides; with out_ready low, input fills then in_ready drops.
// ----------------------------------------------------------------------------
module interleaved_channel_block_averager
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [icba_pkg::SAMPLE_W-1:0]  sample,
    input  logic [icba_pkg::INDEX_W-1:0]   channel_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [icba_pkg::SAMPLE_W-1:0]  reading,
    output logic                           block_done,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [icba_pkg::FRAMES_W-1:0]  cfg_data
);
    import icba_pkg::*;

    logic [CHANS_W-1:0]  channel_count_reg;
    logic [FRAMES_W-1:0] frames_per_block_reg;
    logic [CHANS_W-1:0]  chans;
    logic [FRAMES_W-1:0] frames;
    logic                push_valid;
    logic                push_ready;
    item_t               push_item;
    logic                pop_valid;
    logic                pop;
    item_t               pop_item;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg    <= CHANS_W'(4);
            frames_per_block_reg <= FRAMES_W'(MAX_FRAMES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT:    channel_count_reg    <= cfg_data[CHANS_W-1:0];
                REG_FRAMES_PER_BLOCK: frames_per_block_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign chans  = eff_chans(channel_count_reg);
    assign frames = eff_frames(frames_per_block_reg);

    icba_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .sample        (sample),
        .channel_index (channel_index),
        .chans         (chans),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    icba_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    icba_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    icba_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_item     (pop_item),
        .q_pop      (pop),
        .chans      (chans),
        .frames     (frames),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reading    (reading),
        .block_done (block_done)
    );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - interleaved channel block averager testbench
// Walks a directed table of pushes, reads and register writes covering
// saturated and zero registers, clamped read indexes, mid-block register
// changes and saturating means. It then runs randomised segments under
// several register settings and handshake stall patterns. Every result
// transaction is checked against a typed value or an in-bench model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEGMENTS    = 8;
    localparam int SEG_ITEMS   = 100;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] reading;
        logic                block_done;
    } result_t;

    typedef struct packed
    {
        row_kind_t            kind;
        func_t                op;
        logic [SAMPLE_W-1:0]  sample_val;
        logic [INDEX_W-1:0]   index_val;
        logic                 reg_sel;
        logic [FRAMES_W-1:0]  reg_val;
        logic                 typed;
        result_t              typed_result;
    } row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 func          = FUNC_PUSH;
    logic [SAMPLE_W-1:0]  sample        = '0;
    logic [INDEX_W-1:0]   channel_index = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [SAMPLE_W-1:0]  reading;
    logic                 block_done;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index     = REG_CHANNEL_COUNT;
    logic [FRAMES_W-1:0]  cfg_data      = '0;

    // Model state of the averager
    logic [SUM_W-1:0]       channel_acc [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    channel_mean [MAX_CHANNELS];
    logic [INDEX_W-1:0]     slot_ptr;
    logic [FRAME_POS_W-1:0] frame_ptr;
    logic [CHANS_W-1:0]     cfg_chans;
    logic [FRAMES_W-1:0]    cfg_frames;

    result_t pending_results [$];
    row_t    directed_rows [$];
    int      mismatch_count = 0;
    int      sender_gap_pct = 0;
    int      sink_stall_pct = 0;
    int      hold_left      = 0;
    int      cycle_count    = 0;

    interleaved_channel_block_averager DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .sample        (sample),
        .channel_index (channel_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reading       (reading),
        .block_done    (block_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Store the means of a finished block and clear every accumulator
    function automatic void close_block(input int chans, input int frames);
        int q;
        for (int j = 0; j < MAX_CHANNELS; j++)
        begin
            if (j < chans)
            begin
                q = channel_acc[j] / frames;
                if (q > READING_MAX)
                    q = READING_MAX;
                channel_mean[j] = q[SAMPLE_W-1:0];
            end
            channel_acc[j] = '0;
        end
    endfunction

    // Expected result of one input transaction; advances the model state
    function automatic result_t averager_predict(input func_t op,
                                                 input logic [SAMPLE_W-1:0] s,
                                                 input logic [INDEX_W-1:0] ix);
        result_t            r;
        int                 chans;
        int                 frames;
        int                 pick;
        int                 next_frame;
        logic [SUM_W:0]     total;
        logic [INDEX_W-1:0] next_slot;
        r = '0;
        chans  = (cfg_chans == 0) ? 1 :
                 (cfg_chans > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_chans);
        frames = (cfg_frames == 0) ? 1 :
                 (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_frames);
        if (op == FUNC_READ)
        begin
            // index past the last active channel clamps to it
            pick = ix;
            if (pick > chans - 1)
                pick = chans - 1;
            r.reading = channel_mean[pick];
        end
        else
        begin
            total = {1'b0, channel_acc[slot_ptr]} + s;
            channel_acc[slot_ptr] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
            next_slot = slot_ptr + 1'b1;
            // a slot left beyond a reduced channel count wraps on its next advance
            if (next_slot >= chans || next_slot == 0)
            begin
                slot_ptr   = '0;
                next_frame = frame_ptr + 1;
                if (next_frame >= frames)
                begin
                    next_frame = 0;
                    close_block(chans, frames);
                    r.block_done = 1'b1;
                end
                frame_ptr = next_frame[FRAME_POS_W-1:0];
            end
            else
                slot_ptr = next_slot;
        end
        return r;
    endfunction

    function automatic row_t item_row(input func_t op, input int s, input int ix,
                                      input bit typed, input int t_reading,
                                      input bit t_done);
        row_t r;
        r = '0;
        r.kind         = ROW_ITEM;
        r.op           = op;
        r.sample_val   = s[SAMPLE_W-1:0];
        r.index_val    = ix[INDEX_W-1:0];
        r.typed        = typed;
        r.typed_result = {t_reading[SAMPLE_W-1:0], t_done};
        return r;
    endfunction

    function automatic row_t cfg_row(input logic sel, input int val);
        row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.reg_val = val[FRAMES_W-1:0];
        return r;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // Offer one transaction, with a random gap first; valid is left high
    task automatic offer_item(input func_t op, input logic [SAMPLE_W-1:0] s,
                              input logic [INDEX_W-1:0] ix, input bit typed,
                              input result_t t_result);
        result_t predicted;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= op;
        sample        <= s;
        channel_index <= ix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = averager_predict(op, s, ix);
        pending_results.push_back(typed ? t_result : predicted);
    endtask

    task automatic offer_random_item();
        func_t op;
        op = ($urandom_range(99) < 75) ? FUNC_PUSH : FUNC_READ;
        offer_item(op, SAMPLE_W'($urandom_range(4095)), INDEX_W'($urandom_range(7)),
                   1'b0, '0);
    endtask

    // Drain the outstanding results before touching a register
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [FRAMES_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (sel == REG_CHANNEL_COUNT)
            cfg_chans = val[CHANS_W-1:0];
        else
            cfg_frames = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result sink: random stalls, plus a long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("unexpected result: reading %0d block_done %0b",
                                        reading, block_done));
            else
            begin
                want = pending_results.pop_front();
                if (reading !== want.reading)
                    flag_mismatch($sformatf("reading: expected %0d, got %0d",
                                            want.reading, reading));
                if (block_done !== want.block_done)
                    flag_mismatch($sformatf("block_done: expected %0b, got %0b",
                                            want.block_done, block_done));
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        row_t                row;
        logic [CHANS_W-1:0]  cc_val;
        logic [FRAMES_W-1:0] fpb_val;
        logic [FRAMES_W-1:0] cc_word;
        int                  pick;

        foreach (channel_acc[j])
        begin
            channel_acc[j]  = '0;
            channel_mean[j] = '0;
        end
        slot_ptr   = '0;
        frame_ptr  = '0;
        cfg_chans  = CHANS_W'(4);
        cfg_frames = FRAMES_W'(256);

        // readings start at zero; reads clamp to the last channel
        directed_rows.push_back(item_row(FUNC_READ, 0, 0, 1, 0, 0));
        directed_rows.push_back(item_row(FUNC_READ, 0, 7, 1, 0, 0));
        // zero registers count as one channel and one frame
        directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 0));
        directed_rows.push_back(cfg_row(REG_FRAMES_PER_BLOCK, 0));
        directed_rows.push_back(item_row(FUNC_PUSH, 4095, 3, 1, 0, 1));
        directed_rows.push_back(item_row(FUNC_READ, 0, 5, 1, 4095, 0));
        directed_rows.push_back(item_row(FUNC_PUSH, 0, 0, 1, 0, 1));
        directed_rows.push_back(item_row(FUNC_READ, 4095, 0, 1, 0, 0));
        // oversized registers saturate
        directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 15));
        directed_rows.push_back(cfg_row(REG_FRAMES_PER_BLOCK, 511));
        directed_rows.push_back(item_row(FUNC_PUSH, 4095, 7, 1, 0, 0));
        directed_rows.push_back(item_row(FUNC_PUSH, 4095, 0, 1, 0, 0));
        directed_rows.push_back(item_row(FUNC_READ, 0, 7, 0, 0, 0));
        // slot left beyond a reduced channel count
        directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 2));
        directed_rows.push_back(item_row(FUNC_PUSH, 4095, 0, 0, 0, 0));
        // frame left beyond a reduced block length; means saturate
        directed_rows.push_back(cfg_row(REG_FRAMES_PER_BLOCK, 1));
        directed_rows.push_back(item_row(FUNC_PUSH, 4095, 0, 0, 0, 0));
        directed_rows.push_back(item_row(FUNC_PUSH, 4095, 0, 0, 0, 0));
        directed_rows.push_back(item_row(FUNC_READ, 0, 1, 0, 0, 0));
        directed_rows.push_back(item_row(FUNC_READ, 0, 6, 0, 0, 0));
        // readings of channels inactive at block end are kept
        directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 1));
        directed_rows.push_back(item_row(FUNC_PUSH, 2048, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(REG_CHANNEL_COUNT, 8));
        directed_rows.push_back(item_row(FUNC_READ, 0, 1, 0, 0, 0));
        directed_rows.push_back(item_row(FUNC_READ, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gap_pct = 11;
        sink_stall_pct = 84;
        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.reg_sel, row.reg_val);
            end
            else
                offer_item(row.op, row.sample_val, row.index_val, row.typed,
                           row.typed_result);
        end

        // Random segments, each under its own register setting
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            case (seg)
                0:
                begin
                    cc_val  = CHANS_W'(1);
                    fpb_val = FRAMES_W'(1);
                end
                3:
                begin
                    cc_val  = CHANS_W'(8);
                    fpb_val = FRAMES_W'(256);
                end
                6:
                begin
                    cc_val  = CHANS_W'(8);
                    fpb_val = FRAMES_W'(2);
                end
                default:
                begin
                    cc_val = CHANS_W'($urandom_range(15));
                    pick   = $urandom_range(99);
                    if (pick < 60)
                        fpb_val = FRAMES_W'($urandom_range(6, 1));
                    else if (pick < 70)
                        fpb_val = '0;
                    else if (pick < 80)
                        fpb_val = FRAMES_W'($urandom_range(511, 256));
                    else
                        fpb_val = FRAMES_W'($urandom_range(40, 7));
                end
            endcase
            // upper data bits are ignored for the channel count
            cc_word = {5'($urandom_range(31)), cc_val};
            write_reg(REG_CHANNEL_COUNT, cc_word);
            write_reg(REG_FRAMES_PER_BLOCK, fpb_val);

            if (seg < 3)
            begin
                sender_gap_pct = 11;
                sink_stall_pct = 84;
            end
            else if (seg < 6)
            begin
                sender_gap_pct = 84;
                sink_stall_pct = 11;
            end
            else
            begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            // long sink hold-off so the queue fills and input backs up
            if (seg == 6)
                hold_left = 400;

            repeat (SEG_ITEMS) offer_random_item();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
